// ===== rtl/phb_pkg.sv =====
// Shared types, constants and a checksum helper for the probe header builder.
`timescale 1ns / 1ps

package phb_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MAX_WORDS = 10;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ACC_W     = 20;

  typedef enum logic [2:0] {
    OP_SYN  = 3'd0,
    OP_NULL = 3'd1,
    OP_ACK  = 3'd2,
    OP_FIN  = 3'd3,
    OP_XMAS = 3'd4,
    OP_UDP  = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IP_IDENT     = 3'd0,
    CFG_TIME_TO_LIVE = 3'd1,
    CFG_TCP_SEQUENCE = 3'd2,
    CFG_TCP_WINDOW   = 3'd3
  } cfg_idx_e;

  localparam logic [15:0] RST_IP_IDENT     = 16'd54321;
  localparam logic [7:0]  RST_TIME_TO_LIVE = 8'd255;
  localparam logic [31:0] RST_TCP_SEQUENCE = 32'd12345;
  localparam logic [15:0] RST_TCP_WINDOW   = 16'd5840;

  localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] TCP_TOTAL_LEN  = 16'd40;
  localparam logic [15:0] UDP_TOTAL_LEN  = 16'd28;
  localparam logic [15:0] TCP_SEG_LEN    = 16'd20;
  localparam logic [15:0] UDP_SEG_LEN    = 16'd8;
  localparam logic [7:0]  TCP_DATA_OFF   = 8'h50;
  localparam logic [15:0] CK_ALL_ONES    = 16'hFFFF;

  localparam logic [7:0] FLAG_SYN  = 8'h02;
  localparam logic [7:0] FLAG_NULL = 8'h00;
  localparam logic [7:0] FLAG_ACK  = 8'h10;
  localparam logic [7:0] FLAG_FIN  = 8'h01;
  localparam logic [7:0] FLAG_XMAS = 8'h29;

  localparam logic [CNT_W-1:0] TCP_WORDS = 4'd10;
  localparam logic [CNT_W-1:0] UDP_WORDS = 4'd7;

  typedef struct packed {
    logic [15:0] ip_ident;
    logic [7:0]  time_to_live;
    logic [31:0] tcp_sequence;
    logic [15:0] tcp_window;
  } cfg_t;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] target_address;
    logic [15:0] source_port;
    logic [15:0] target_port;
    logic [2:0]  operation;
  } item_t;

  typedef struct packed {
    logic [MAX_WORDS-1:0][WORD_W-1:0] words;
    logic [CNT_W-1:0]                 count;
    logic                             emit;
  } probe_t;

  // two end-around folds, then complement
  function automatic logic [15:0] fold_invert(input logic [ACC_W-1:0] acc);
    logic [16:0] s1;
    logic [15:0] s2;
    s1 = {1'b0, acc[15:0]} + 17'(acc[ACC_W-1:16]);
    s2 = s1[15:0] + 16'(s1[16]);
    return ~s2;
  endfunction

endpackage

// ===== rtl/phb_cfg_regs.sv =====
// Configuration register file: identification, TTL, sequence and window.
`timescale 1ns / 1ps

module phb_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [phb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  output phb_pkg::cfg_t                 cfg_o
);
  import phb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IP_IDENT:     cfg_d.ip_ident     = cfg_data_i[15:0];
        CFG_TIME_TO_LIVE: cfg_d.time_to_live = cfg_data_i[7:0];
        CFG_TCP_SEQUENCE: cfg_d.tcp_sequence = cfg_data_i;
        CFG_TCP_WINDOW:   cfg_d.tcp_window   = cfg_data_i[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ip_ident     <= RST_IP_IDENT;
      cfg_q.time_to_live <= RST_TIME_TO_LIVE;
      cfg_q.tcp_sequence <= RST_TCP_SEQUENCE;
      cfg_q.tcp_window   <= RST_TCP_WINDOW;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/phb_csum.sv =====
// Header assembly: builds all words of one probe including both checksums.
`timescale 1ns / 1ps

module phb_csum (
  input  phb_pkg::item_t  item_i,
  input  phb_pkg::cfg_t   cfg_i,
  output phb_pkg::probe_t probe_o
);
  import phb_pkg::*;

  logic              is_tcp, is_udp;
  logic [7:0]        flags;
  logic [7:0]        proto;
  logic [15:0]       total_len;
  logic [15:0]       seg_len;
  logic [ACC_W-1:0]  addr_acc;
  logic [ACC_W-1:0]  ip_acc;
  logic [ACC_W-1:0]  l4_acc;
  logic [15:0]       ip_ck;
  logic [15:0]       l4_ck;
  logic [15:0]       udp_ck;

  always_comb begin
    is_tcp = 1'b1;
    is_udp = 1'b0;
    case (item_i.operation)
      OP_SYN:  flags = FLAG_SYN;
      OP_NULL: flags = FLAG_NULL;
      OP_ACK:  flags = FLAG_ACK;
      OP_FIN:  flags = FLAG_FIN;
      OP_XMAS: flags = FLAG_XMAS;
      OP_UDP: begin
        flags  = FLAG_NULL;
        is_tcp = 1'b0;
        is_udp = 1'b1;
      end
      default: begin
        flags  = FLAG_NULL;
        is_tcp = 1'b0;
      end
    endcase
  end

  assign proto     = is_udp ? PROTO_UDP : PROTO_TCP;
  assign total_len = is_udp ? UDP_TOTAL_LEN : TCP_TOTAL_LEN;
  assign seg_len   = is_udp ? UDP_SEG_LEN : TCP_SEG_LEN;

  // address halves appear in both the IP header and the pseudo-header
  assign addr_acc = ACC_W'(item_i.source_address[31:16]) + ACC_W'(item_i.source_address[15:0])
                  + ACC_W'(item_i.target_address[31:16]) + ACC_W'(item_i.target_address[15:0]);

  assign ip_acc = addr_acc + ACC_W'(IP_VER_IHL_TOS) + ACC_W'(total_len)
                + ACC_W'(cfg_i.ip_ident) + ACC_W'({cfg_i.time_to_live, proto});

  assign l4_acc = addr_acc + ACC_W'(proto) + ACC_W'(seg_len)
                + ACC_W'(item_i.source_port) + ACC_W'(item_i.target_port)
                + (is_udp ? ACC_W'(UDP_SEG_LEN)
                          : ACC_W'(cfg_i.tcp_sequence[31:16])
                            + ACC_W'(cfg_i.tcp_sequence[15:0])
                            + ACC_W'({TCP_DATA_OFF, flags})
                            + ACC_W'(cfg_i.tcp_window));

  assign ip_ck  = fold_invert(ip_acc);
  assign l4_ck  = fold_invert(l4_acc);
  // zero means "no checksum" for UDP
  assign udp_ck = (l4_ck == 16'h0) ? CK_ALL_ONES : l4_ck;

  always_comb begin
    probe_o.words    = '0;
    probe_o.words[0] = {IP_VER_IHL_TOS, total_len};
    probe_o.words[1] = {cfg_i.ip_ident, 16'h0};
    probe_o.words[2] = {cfg_i.time_to_live, proto, ip_ck};
    probe_o.words[3] = item_i.source_address;
    probe_o.words[4] = item_i.target_address;
    probe_o.words[5] = {item_i.source_port, item_i.target_port};
    if (is_udp) begin
      probe_o.words[6] = {UDP_SEG_LEN, udp_ck};
    end else begin
      probe_o.words[6] = cfg_i.tcp_sequence;
      probe_o.words[8] = {TCP_DATA_OFF, flags, cfg_i.tcp_window};
      probe_o.words[9] = {l4_ck, 16'h0};
    end
    probe_o.count = is_udp ? UDP_WORDS : TCP_WORDS;
    probe_o.emit  = is_tcp | is_udp;
  end

endmodule

// ===== rtl/phb_out.sv =====
// Result register: holds one built probe and shifts its words out.
`timescale 1ns / 1ps

module phb_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  phb_pkg::probe_t            probe_i,
  output logic                       free_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [phb_pkg::WORD_W-1:0] header_word_o,
  output logic                       last_word_o
);
  import phb_pkg::*;

  logic [MAX_WORDS-1:0][WORD_W-1:0] words_q, words_d;
  logic [CNT_W-1:0]                 rem_q, rem_d;
  logic                             fire;

  assign out_valid_o   = (rem_q != '0);
  assign last_word_o   = (rem_q == CNT_W'(1));
  assign header_word_o = words_q[0];
  assign fire          = out_valid_o && !out_stall_i;
  assign free_o        = !out_valid_o || (fire && last_word_o);

  always_comb begin
    words_d = words_q;
    rem_d   = rem_q;
    if (load_i) begin
      words_d = probe_i.words;
      rem_d   = probe_i.count;
    end else if (fire) begin
      words_d = {{WORD_W{1'b0}}, words_q[MAX_WORDS-1:1]};
      rem_d   = rem_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    words_q <= words_d;
  end

endmodule

// ===== rtl/probe_header_builder.sv =====
// Top level of the probe header builder: request register, header build, word output.
`timescale 1ns / 1ps

// Each request is registered, its IPv4 and TCP/UDP headers with both
// checksums are built in one step into the result register, and the words
// then leave one per cycle on the output channel while it is not stalled,
// first byte on the wire in bits 31..24. A TCP probe (SYN, NULL, ACK, FIN,
// XMAS) has 10 words, a UDP probe 7; unused kinds 6 and 7 produce no words
// and are dropped without waiting for the result register. The output port
// is the bottleneck. The request register takes the next request while the
// current probe drains, and its headers are loaded in the cycle the last
// word of the current probe is taken. Configure only while idle.

module probe_header_builder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [phb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   source_address_i,
  input  logic [31:0]                   target_address_i,
  input  logic [15:0]                   source_port_i,
  input  logic [15:0]                   target_port_i,
  input  logic [2:0]                    operation_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   header_word_o,
  output logic                          last_word_o
);
  import phb_pkg::*;

  cfg_t   cfg;
  item_t  item_q;
  probe_t probe;
  logic   req_vld_q, req_vld_d;
  logic   in_fire;
  logic   req_take;
  logic   out_free;

  phb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // kinds without output drop without waiting for the result register
  assign req_take   = req_vld_q && (!probe.emit || out_free);
  assign in_stall_o = req_vld_q && !req_take;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    req_vld_d = req_vld_q;
    if (in_fire) begin
      req_vld_d = 1'b1;
    end else if (req_take) begin
      req_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= req_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.source_address <= source_address_i;
      item_q.target_address <= target_address_i;
      item_q.source_port    <= source_port_i;
      item_q.target_port    <= target_port_i;
      item_q.operation      <= operation_i;
    end
  end

  phb_csum u_csum (
    .item_i  (item_q),
    .cfg_i   (cfg),
    .probe_o (probe)
  );

  phb_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (req_take && probe.emit),
    .probe_i       (probe),
    .free_o        (out_free),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .header_word_o (header_word_o),
    .last_word_o   (last_word_o)
  );

endmodule

// ===== rtl/phb_checker.sv =====
// Port-level checker for the probe header builder, bound to the top level.
`timescale 1ns / 1ps

module phb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] header_word_o,
  input logic        last_word_o
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(header_word_o)
                                   && $stable(last_word_o))
    else $error("stalled output word changed");

  // a probe's words leave without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=> out_valid_o)
    else $error("gap inside a probe");

  // the word after a probe's last word opens a new IPv4 header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_word_o ##1 out_valid_o
      |-> header_word_o[31:16] == 16'h4500)
    else $error("probe does not start with an IPv4 header word");

  // the request side only waits behind a probe in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("request stalled with no probe in output");

endmodule

bind probe_header_builder phb_checker u_phb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .header_word_o (header_word_o),
  .last_word_o   (last_word_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the probe header builder: directed table, then random probes.
`timescale 1ns / 1ps

module tb_top;
  import phb_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 16;
  localparam int MAX_REPORTS    = 100;
  localparam int DIR_ROWS       = 21;

  // kinds 6 and 7 carry no probe
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd4;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } hdr_word_t;

  typedef struct {
    item_t       req;
    bit          typed;
    int          n_words;
    logic [31:0] words [10];
  } probe_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [31:0]          req_src_ip = '0;
  logic [31:0]          req_dst_ip = '0;
  logic [15:0]          req_sport = '0;
  logic [15:0]          req_dport = '0;
  logic [2:0]           op_code = '0;
  logic                 out_stall = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] header_word_o;
  logic        last_word_o;

  int send_idle_pct = 19;
  int recv_idle_pct = 52;
  int mismatches = 0;

  cfg_t      probe_cfg;
  hdr_word_t expected_words [$];

  probe_row_t directed_rows [DIR_ROWS] = '{
    // all-zero SYN at reset settings
    '{'{32'h0, 32'h0, 16'h0, 16'h0, OP_SYN}, 1'b1, 10,
      '{32'h45000028, 32'hD4310000, 32'hFF06E79E, 32'h0, 32'h0,
        32'h0, 32'h00003039, 32'h0, 32'h500216D0, 32'h68DA0000}},
    // UDP sum folds to 0xFFFF, so the checksum goes out as all ones
    '{'{32'h0, 32'h0, 16'hFFDE, 16'h0, OP_UDP}, 1'b1, 7,
      '{32'h4500001C, 32'hD4310000, 32'hFF11E79F, 32'h0, 32'h0,
        32'hFFDE0000, 32'h0008FFFF, 32'h0, 32'h0, 32'h0}},
    '{'{32'h0, 32'h0, 16'h0, 16'h0, OP_SPARE_A}, 1'b1, 0, '{default: 32'h0}},
    '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, OP_SPARE_B}, 1'b1, 0,
      '{default: 32'h0}},
    '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, OP_SYN}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, OP_UDP}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'h0, 32'h0, 16'h0, 16'h0, OP_UDP}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'hC0A80001, 32'hC0A800FE, 16'h1F90, 16'h0050, OP_NULL}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'h0A000001, 32'h08080808, 16'h8000, 16'h01BB, OP_ACK}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 16'h5555, OP_FIN}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'hAAAA, OP_XMAS}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'hFFFF0000, 32'h0000FFFF, 16'h0000, 16'hFFFF, OP_SYN}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'h7F000001, 32'h7F000001, 16'hFFFF, 16'h0000, OP_UDP}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'h0, 32'hFFFFFFFF, 16'h0001, 16'h8000, OP_XMAS}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'h12345678, 32'h9ABCDEF0, 16'h4321, 16'h8765, OP_SPARE_A}, 1'b1, 0,
      '{default: 32'h0}},
    '{'{32'h80000000, 32'h00000001, 16'h7FFF, 16'h0001, OP_ACK}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'h01020304, 32'h05060708, 16'h0035, 16'h0035, OP_UDP}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'hFEDCBA98, 32'h76543210, 16'hABCD, 16'hEF01, OP_FIN}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'h0, 32'h0, 16'h0, 16'h0, OP_NULL}, 1'b0, 0, '{default: 32'h0}},
    '{'{32'hC6336401, 32'hC6336402, 16'h0400, 16'h0016, OP_SPARE_B}, 1'b1, 0,
      '{default: 32'h0}},
    '{'{32'h01010101, 32'h02020202, 16'h0000, 16'h0000, OP_SYN}, 1'b0, 0, '{default: 32'h0}}
  };

  probe_header_builder dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .source_address_i (req_src_ip),
    .target_address_i (req_dst_ip),
    .source_port_i    (req_sport),
    .target_port_i    (req_dport),
    .operation_i      (op_code),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .header_word_o    (header_word_o),
    .last_word_o      (last_word_o)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] add_halves(input logic [31:0] acc, input logic [31:0] w);
    return acc + {16'h0, w[31:16]} + {16'h0, w[15:0]};
  endfunction

  function automatic logic [15:0] fold_complement(input logic [31:0] acc);
    logic [31:0] s;
    s = {16'h0, acc[31:16]} + {16'h0, acc[15:0]};
    s = {16'h0, s[31:16]} + {16'h0, s[15:0]};
    return ~s[15:0];
  endfunction

  // Appends the header words one probe request should produce.
  function automatic void build_probe_words(input item_t req);
    logic [31:0] w [10];
    logic [31:0] acc;
    logic [15:0] ck;
    logic [7:0]  flags;
    logic [7:0]  proto;
    logic [15:0] seg_len;
    bit          is_udp;
    int          n_words;
    flags = 8'h00;
    case (req.operation)
      OP_SYN:  flags = 8'h02;
      OP_NULL: flags = 8'h00;
      OP_ACK:  flags = 8'h10;
      OP_FIN:  flags = 8'h01;
      OP_XMAS: flags = 8'h29;  // FIN | PSH | URG
      OP_UDP:  ;
      default: return;
    endcase
    is_udp  = (req.operation == OP_UDP);
    proto   = is_udp ? 8'd17 : 8'd6;
    seg_len = is_udp ? 16'd8 : 16'd20;

    w[0] = {16'h4500, 16'd20 + seg_len};
    w[1] = {probe_cfg.ip_ident, 16'h0};
    w[2] = {probe_cfg.time_to_live, proto, 16'h0};
    w[3] = req.source_address;
    w[4] = req.target_address;
    acc = '0;
    for (int i = 0; i < 5; i++) acc = add_halves(acc, w[i]);
    w[2][15:0] = fold_complement(acc);

    // pseudo-header
    acc = add_halves(32'h0, req.source_address);
    acc = add_halves(acc, req.target_address);
    acc = add_halves(acc, {8'h0, proto, seg_len});

    w[5] = {req.source_port, req.target_port};
    if (is_udp) begin
      w[6] = {seg_len, 16'h0};
      acc = add_halves(acc, w[5]);
      acc = add_halves(acc, w[6]);
      ck = fold_complement(acc);
      if (ck == 16'h0) ck = 16'hFFFF;
      w[6][15:0] = ck;
      n_words = 7;
    end else begin
      w[6] = probe_cfg.tcp_sequence;
      w[7] = 32'h0;
      w[8] = {8'h50, flags, probe_cfg.tcp_window};
      w[9] = 32'h0;
      for (int i = 5; i < 10; i++) acc = add_halves(acc, w[i]);
      w[9] = {fold_complement(acc), 16'h0};
      n_words = 10;
    end
    for (int i = 0; i < n_words; i++)
      expected_words.push_back(hdr_word_t'{word: w[i], last: (i == n_words - 1)});
  endfunction

  function automatic logic [31:0] rand_word32();
    case ($urandom_range(7))
      0:       return 32'h0;
      1:       return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_half();
    case ($urandom_range(7))
      0:       return 16'h0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_REPORTS)
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Leaves in_valid high once the request is taken; the next call lowers it if it idles.
  task automatic send_request(input item_t req, input bit predict);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_src_ip <= req.source_address;
    req_dst_ip <= req.target_address;
    req_sport  <= req.source_port;
    req_dport  <= req.target_port;
    op_code    <= req.operation;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    if (predict) build_probe_words(req);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    // spare kinds give no words but may still sit in the request register
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_IP_IDENT:     probe_cfg.ip_ident     = data[15:0];
      CFG_TIME_TO_LIVE: probe_cfg.time_to_live = data[7:0];
      CFG_TCP_SEQUENCE: probe_cfg.tcp_sequence = data;
      CFG_TCP_WINDOW:   probe_cfg.tcp_window   = data[15:0];
      default:          ;
    endcase
  endtask

  // Upper data bits beyond each register's width are written too and must be dropped.
  task automatic program_config(input logic [31:0] ident, input logic [31:0] ttl,
                                input logic [31:0] seq, input logic [31:0] win);
    write_register(CFG_IP_IDENT, ident);
    write_register(CFG_TIME_TO_LIVE, ttl);
    write_register(CFG_TCP_SEQUENCE, seq);
    write_register(CFG_TCP_WINDOW, win);
    write_register(CFG_IDX_W'(CFG_UNUSED_LO + $urandom_range(3)), $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    bit use_typed;
    for (int r = 0; r < DIR_ROWS; r++) begin
      use_typed = directed_rows[r].typed;
      send_request(directed_rows[r].req, !use_typed);
      if (use_typed)
        for (int k = 0; k < directed_rows[r].n_words; k++)
          expected_words.push_back(hdr_word_t'{word: directed_rows[r].words[k],
                                               last: (k == directed_rows[r].n_words - 1)});
    end
  endtask

  task automatic run_random(input int probes);
    int    done;
    item_t req;
    done = 0;
    while (done < probes) begin
      req.source_address = rand_word32();
      req.target_address = rand_word32();
      req.source_port    = rand_half();
      req.target_port    = rand_half();
      if ($urandom_range(99) < 8)
        req.operation = $urandom_range(1) ? OP_SPARE_B : OP_SPARE_A;
      else
        req.operation = 3'($urandom_range(OP_UDP));
      send_request(req, 1'b1);
      done++;
      if ($urandom_range(99) < 2) begin
        wait_idle();
        program_config(rand_word32(), rand_word32(), rand_word32(), rand_word32());
      end else if ($urandom_range(99) < 3) begin
        wait_idle();
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    hdr_word_t exp_w;
    if (rst_n && out_valid_o && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("header_word with no probe pending", header_word_o, 32'h0);
      end else begin
        exp_w = expected_words.pop_front();
        if (header_word_o !== exp_w.word)
          report_mismatch("header_word", header_word_o, exp_w.word);
        if (last_word_o !== exp_w.last)
          report_mismatch("last_word", 32'(last_word_o), 32'(exp_w.last));
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    probe_cfg.ip_ident     = RST_IP_IDENT;
    probe_cfg.time_to_live = RST_TIME_TO_LIVE;
    probe_cfg.tcp_sequence = RST_TCP_SEQUENCE;
    probe_cfg.tcp_window   = RST_TCP_WINDOW;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_idle();

    program_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    run_random(136);
    wait_idle();

    send_idle_pct <= 52;
    recv_idle_pct <= 19;
    program_config(32'h0, 32'h0, 32'h0, 32'h0);
    run_random(136);
    wait_idle();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    program_config(rand_word32(), rand_word32(), rand_word32(), rand_word32());
    run_random(137);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
